// ===== hdl/snils_pkg.sv =====
`timescale 1ns / 1ps

package snils_pkg;

	// widths of the number and of its decimal form
	localparam int NUM_W       = 37;
	localparam int DIGIT_W     = 4;
	localparam int NUM_DIGITS  = 11;
	localparam int BODY_DIGITS = 9;
	localparam int CHECK_W     = 7;
	// weighted sum peaks at 9 * 45 = 405
	localparam int SUM_W       = 9;

	// check value rule
	localparam logic [SUM_W-1:0] CHECK_MOD   = SUM_W'(101);
	localparam logic [SUM_W-1:0] CHECK_LIMIT = SUM_W'(100);
	localparam logic [SUM_W-1:0] CHECK_MOD2  = SUM_W'(2 * 101);
	localparam logic [SUM_W-1:0] CHECK_MOD3  = SUM_W'(3 * 101);
	localparam logic [SUM_W-1:0] CHECK_MOD4  = SUM_W'(4 * 101);

	typedef logic [DIGIT_W-1:0] digit_t;

	// input word
	typedef struct packed {
		logic [NUM_W-1:0] number_value;
	} num_word_t;

	// lowest eleven decimal digits, digit[0] least significant
	typedef struct packed {
		digit_t [NUM_DIGITS-1:0] digit;
	} bcd_word_t;

	// body sum, given check value and run flag
	typedef struct packed {
		logic [SUM_W-1:0]   sum;
		logic [CHECK_W-1:0] given;
		logic               repeat_fault;
	} sum_info_t;

	// result word
	typedef struct packed {
		logic               is_valid;
		logic               checksum_ok;
		logic               repeat_fault;
		logic [CHECK_W-1:0] expected_check;
	} result_word_t;

	// one double-dabble step: add 3 to digits of 5 or more, shift in the next bit
	function automatic bcd_word_t dabble_step(bcd_word_t b, logic msb);
		bcd_word_t                        adj;
		logic [NUM_DIGITS*DIGIT_W-1:0]    flat;
		adj = b;
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (b.digit[d] >= digit_t'(5)) begin
				adj.digit[d] = b.digit[d] + digit_t'(3);
			end
		end
		flat = adj;
		return {flat[NUM_DIGITS*DIGIT_W-2:0], msb};
	endfunction

endpackage

// ===== hdl/snils_stream_if.sv =====
`timescale 1ns / 1ps

interface snils_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/snils_bcd_split.sv =====
`timescale 1ns / 1ps

module snils_bcd_split #(
	parameter int DABBLE_STEPS = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	snils_stream_if.sink   number,
	snils_stream_if.source bcd
);
	import snils_pkg::*;

	localparam int NumStages = (NUM_W + DABBLE_STEPS - 1) / DABBLE_STEPS;

	logic [NumStages-1:0] vld_s;
	logic [NumStages:0]   rdy;
	logic [NUM_W-1:0]     bin_s [NumStages];
	bcd_word_t            bcd_s [NumStages];

	// a stage takes a word when empty or when the next one moves on
	assign rdy[NumStages] = bcd.ready;
	assign number.ready   = rdy[0];

	for (genvar k = 0; k < NumStages; k++) begin : g_stage
		localparam int Left  = NUM_W - k * DABBLE_STEPS;
		localparam int Steps = (Left < DABBLE_STEPS) ? Left : DABBLE_STEPS;

		logic [NUM_W-1:0] bin_in;
		logic [NUM_W-1:0] bin_nx;
		bcd_word_t        bcd_in;
		bcd_word_t        bcd_nx;
		logic             vld_in;

		if (k == 0) begin : g_first
			assign bin_in = number.payload.number_value;
			assign bcd_in = '0;
			assign vld_in = number.valid;
		end else begin : g_next
			assign bin_in = bin_s[k-1];
			assign bcd_in = bcd_s[k-1];
			assign vld_in = vld_s[k-1];
		end

		// this stage's share of the binary to decimal conversion
		always_comb begin
			bin_nx = bin_in;
			bcd_nx = bcd_in;
			for (int i = 0; i < DABBLE_STEPS; i++) begin
				if (i < Steps) begin
					bcd_nx = dabble_step(bcd_nx, bin_nx[NUM_W-1]);
					bin_nx = {bin_nx[NUM_W-2:0], 1'b0};
				end
			end
		end

		assign rdy[k] = !vld_s[k] || rdy[k+1];

		// stage valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= vld_in;
			end
		end

		// stage data
		always_ff @(posedge clk) begin
			if (rdy[k] && vld_in) begin
				bin_s[k] <= bin_nx;
				bcd_s[k] <= bcd_nx;
			end
		end
	end

	assign bcd.valid   = vld_s[NumStages-1];
	assign bcd.payload = bcd_s[NumStages-1];

endmodule

// ===== hdl/snils_check_calc.sv =====
`timescale 1ns / 1ps

module snils_check_calc (
	input  logic           clk,
	input  logic           arst_n,
	snils_stream_if.sink   bcd,
	snils_stream_if.source info
);
	import snils_pkg::*;

	logic      vld_q;
	sum_info_t info_q;
	sum_info_t info_nx;

	assign bcd.ready = !vld_q || info.ready;

	// weighted body sum, given check value, runs of three equal digits
	always_comb begin
		info_nx.sum = '0;
		for (int j = 2; j < NUM_DIGITS; j++) begin
			info_nx.sum = info_nx.sum
				+ SUM_W'(bcd.payload.digit[j]) * SUM_W'(j - 1);
		end
		info_nx.given = CHECK_W'(bcd.payload.digit[1]) * CHECK_W'(10)
			+ CHECK_W'(bcd.payload.digit[0]);
		info_nx.repeat_fault = 1'b0;
		for (int j = 2; j < NUM_DIGITS - 2; j++) begin
			if (bcd.payload.digit[j] == bcd.payload.digit[j+1]
					&& bcd.payload.digit[j+1] == bcd.payload.digit[j+2]) begin
				info_nx.repeat_fault = 1'b1;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (bcd.ready) begin
			vld_q <= bcd.valid;
		end
	end

	// output data
	always_ff @(posedge clk) begin
		if (bcd.ready && bcd.valid) begin
			info_q <= info_nx;
		end
	end

	assign info.valid   = vld_q;
	assign info.payload = info_q;

endmodule

// ===== hdl/snils_number_validator.sv =====
`timescale 1ns / 1ps

// Insurance number check-digit validator. Each word on number carries an
// eleven-digit value (nine body digits, then two check digits; digits above
// the eleventh are ignored) and yields exactly one word on result with the
// expected check value, the checksum match, the three-equal-digits flag and
// the overall verdict. One word is taken per clock cycle when result keeps
// up. The binary to decimal conversion runs as a pipeline doing up to
// DABBLE_STEPS double-dabble steps per stage, followed by one stage for the
// weighted sum and one for the mod-101 reduction into the result register.
// Every stage holds one word, so words keep flowing into the empty stages
// of the pipeline while a finished result waits to be taken.
module snils_number_validator #(
	parameter int DABBLE_STEPS = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	snils_stream_if.sink   number,
	snils_stream_if.source result
);
	import snils_pkg::*;

	snils_stream_if #(.payload_t(bcd_word_t)) bcd_st ();
	snils_stream_if #(.payload_t(sum_info_t)) info_st ();

	snils_bcd_split #(
		.DABBLE_STEPS(DABBLE_STEPS)
	) u_split (
		.clk    (clk),
		.arst_n (arst_n),
		.number (number),
		.bcd    (bcd_st.source)
	);

	snils_check_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.bcd    (bcd_st.sink),
		.info   (info_st.source)
	);

	logic             res_vld_q;
	result_word_t     res_q;
	logic [SUM_W-1:0] rem;
	logic [SUM_W-1:0] expect_val;
	result_word_t     res_nx;

	assign info_st.ready = !res_vld_q || result.ready;

	// sum mod 101 for sums up to 405, remainder 100 folds to 0
	always_comb begin
		priority if (info_st.payload.sum >= CHECK_MOD4) begin
			rem = info_st.payload.sum - CHECK_MOD4;
		end else if (info_st.payload.sum >= CHECK_MOD3) begin
			rem = info_st.payload.sum - CHECK_MOD3;
		end else if (info_st.payload.sum >= CHECK_MOD2) begin
			rem = info_st.payload.sum - CHECK_MOD2;
		end else if (info_st.payload.sum >= CHECK_MOD) begin
			rem = info_st.payload.sum - CHECK_MOD;
		end else begin
			rem = info_st.payload.sum;
		end
		expect_val = (rem == CHECK_LIMIT) ? '0 : rem;

		res_nx.expected_check = CHECK_W'(expect_val);
		res_nx.checksum_ok    = (info_st.payload.given == CHECK_W'(expect_val));
		res_nx.repeat_fault   = info_st.payload.repeat_fault;
		res_nx.is_valid       = res_nx.checksum_ok && !info_st.payload.repeat_fault;
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (info_st.ready) begin
			res_vld_q <= info_st.valid;
		end
	end

	// result data
	always_ff @(posedge clk) begin
		if (info_st.ready && info_st.valid) begin
			res_q <= res_nx;
		end
	end

	assign result.valid   = res_vld_q;
	assign result.payload = res_q;

	// verdict agrees with its two flags
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.payload.is_valid ==
			(result.payload.checksum_ok && !result.payload.repeat_fault)))
		else $error("verdict does not match checksum and repeat flags");

	// check value stays in two decimal digits
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.payload.expected_check <= CHECK_W'(99)))
		else $error("expected check value above 99");

	// an empty result register opens the whole pipeline
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> number.ready)
		else $error("input stalled while result register is empty");

	// a word handed on by the sum stage lands in the result register next cycle
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(info_st.valid && info_st.ready) |=> result.valid)
		else $error("sum stage word lost on its way to the result register");

endmodule

// ===== dv/snils_tb_pkg.sv =====
`timescale 1ns / 1ps

package snils_tb_pkg;
	import snils_pkg::*;

	// body digits, index 0 is the most significant and carries weight 9
	typedef digit_t [BODY_DIGITS-1:0] body_digits_t;

	// lowest eleven decimal digits: nine body digits and the two-digit check
	function automatic void split_number(input longint unsigned value,
			output body_digits_t dig, output int unsigned given);
		longint unsigned rest;
		rest = value;
		given = int'(rest % 100);
		rest = rest / 100;
		for (int i = BODY_DIGITS - 1; i >= 0; i--) begin
			dig[i] = digit_t'(rest % 10);
			rest = rest / 10;
		end
	endfunction

	// weighted sum 9..1, kept as is below the limit, else folded mod 101
	function automatic int unsigned check_of(input body_digits_t dig);
		int unsigned sum;
		int unsigned folded;
		sum = 0;
		for (int i = 0; i < BODY_DIGITS; i++) begin
			sum += int'(dig[i]) * (BODY_DIGITS - i);
		end
		if (sum < CHECK_LIMIT) begin
			return sum;
		end
		folded = sum % CHECK_MOD;
		return (folded == CHECK_LIMIT) ? 0 : folded;
	endfunction

endpackage

// ===== dv/snils_checker.sv =====
`timescale 1ns / 1ps

module snils_checker
	import snils_pkg::*;
	import snils_tb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         number_valid,
	input  logic         number_ready,
	input  num_word_t    number_word,
	input  logic         result_valid,
	input  logic         result_ready,
	input  result_word_t result_word,
	output int           fail_count,
	output int           pending
);

	localparam int PRINT_CAP = 60;

	typedef struct packed {
		logic [NUM_W-1:0] number;
		result_word_t     verdict;
	} expectation_t;

	expectation_t verdict_q[$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// flags and check value that a number must produce
	function automatic result_word_t predict_verdict(input logic [NUM_W-1:0] number);
		body_digits_t dig;
		int unsigned given;
		int unsigned check;
		logic triple;
		result_word_t r;
		split_number(number, dig, given);
		check = check_of(dig);
		triple = 1'b0;
		for (int i = 1; i < BODY_DIGITS - 1; i++) begin
			if (dig[i-1] == dig[i] && dig[i] == dig[i+1]) begin
				triple = 1'b1;
			end
		end
		r.checksum_ok = (given == check);
		r.repeat_fault = triple;
		r.is_valid = r.checksum_ok && !triple;
		r.expected_check = CHECK_W'(check);
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		if (fail_count < PRINT_CAP) begin
			$display("%0t ns mismatch: %s", $time, what);
		end
		fail_count++;
	endtask

	// record each accepted number, compare each taken result word in order
	always @(posedge clk) begin
		expectation_t want;
		if (arst_n) begin
			if (number_valid && number_ready) begin
				want.number = number_word.number_value;
				want.verdict = predict_verdict(number_word.number_value);
				verdict_q = {verdict_q, want};
			end
			if (result_valid && result_ready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch($sformatf("result word %h with nothing expected",
						result_word));
				end else begin
					want = verdict_q.pop_front();
					if (result_word.is_valid !== want.verdict.is_valid) begin
						report_mismatch($sformatf("number %0d is_valid %b want %b",
							want.number, result_word.is_valid, want.verdict.is_valid));
					end
					if (result_word.checksum_ok !== want.verdict.checksum_ok) begin
						report_mismatch($sformatf("number %0d checksum_ok %b want %b",
							want.number, result_word.checksum_ok,
							want.verdict.checksum_ok));
					end
					if (result_word.repeat_fault !== want.verdict.repeat_fault) begin
						report_mismatch($sformatf("number %0d repeat_fault %b want %b",
							want.number, result_word.repeat_fault,
							want.verdict.repeat_fault));
					end
					if (result_word.expected_check !== want.verdict.expected_check) begin
						report_mismatch($sformatf("number %0d expected_check %0d want %0d",
							want.number, result_word.expected_check,
							want.verdict.expected_check));
					end
				end
			end
			pending <= verdict_q.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import snils_pkg::*;
	import snils_tb_pkg::*;

	localparam int RESET_CYCLES    = 5;
	localparam int LATENCY         = 10;
	localparam int IDLE_PERCENT    = 35;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int STEADY_ITEMS    = 150;
	localparam int HOLD_OFF_ITEMS  = 40;
	localparam int TAIL_ITEMS      = 240;
	localparam longint unsigned TOP_NUMBER = 64'd99999999999;
	localparam longint unsigned NUM_MAX    = (64'd1 << NUM_W) - 1;

	logic clk;
	logic arst_n;
	bit steady;
	bit hold_off_req;
	int fail_count;
	int pending;
	longint cycles = 0;

	snils_stream_if #(.payload_t(num_word_t))    number_ch ();
	snils_stream_if #(.payload_t(result_word_t)) result_ch ();

	snils_number_validator uut (
		.clk    (clk),
		.arst_n (arst_n),
		.number (number_ch),
		.result (result_ch)
	);

	snils_checker verdict_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.number_valid (number_ch.valid),
		.number_ready (number_ch.ready),
		.number_word  (number_ch.payload),
		.result_valid (result_ch.valid),
		.result_ready (result_ch.ready),
		.result_word  (result_ch.payload),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side: random stalls, or one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				result_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
			end
		end
	end

	function automatic longint unsigned compose(input body_digits_t dig,
			input int unsigned check);
		longint unsigned v;
		v = 0;
		for (int i = 0; i < BODY_DIGITS; i++) begin
			v = v * 10 + dig[i];
		end
		return v * 100 + check;
	endfunction

	// body digits reaching a chosen weighted sum, heaviest digits first
	function automatic body_digits_t body_for_sum(input int unsigned target);
		body_digits_t dig;
		int unsigned rest;
		int unsigned w;
		int unsigned d;
		rest = target;
		for (int i = 0; i < BODY_DIGITS; i++) begin
			w = BODY_DIGITS - i;
			d = rest / w;
			if (d > 9) begin
				d = 9;
			end
			dig[i] = digit_t'(d);
			rest -= d * w;
		end
		return dig;
	endfunction

	function automatic longint unsigned random_number();
		body_digits_t dig;
		int unsigned pick;
		int unsigned pos;
		int unsigned target;
		longint unsigned raw;
		pick = $urandom_range(0, 99);
		raw = {$urandom(), $urandom()};
		for (int i = 0; i < BODY_DIGITS; i++) begin
			dig[i] = digit_t'($urandom_range(0, 9));
		end
		// well-formed number with random body
		if (pick < 45) begin
			return compose(dig, check_of(dig));
		end
		// random check digits
		if (pick < 60) begin
			return compose(dig, $urandom_range(0, 99));
		end
		// sum at or near the fold points or anywhere up to 405, sometimes one off
		if (pick < 70) begin
			if ($urandom_range(0, 1) == 0) begin
				target = CHECK_MOD * $urandom_range(1, 4) + $urandom_range(0, 2) - 1;
			end else begin
				target = $urandom_range(0, 405);
			end
			dig = body_for_sum(target);
			return compose(dig, (check_of(dig) + ($urandom_range(0, 3) == 0)) % 100);
		end
		// forced run of three equal body digits
		if (pick < 80) begin
			pos = $urandom_range(0, BODY_DIGITS - 3);
			dig[pos+1] = dig[pos];
			dig[pos+2] = dig[pos];
			return compose(dig, check_of(dig));
		end
		// any value of the full width
		if (pick < 90) begin
			return raw & NUM_MAX;
		end
		// above eleven digits
		return TOP_NUMBER + 1 + raw % (NUM_MAX - TOP_NUMBER);
	endfunction

	// offer one word after random idle cycles, return once it is taken
	task automatic send_number(input longint unsigned value);
		while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			number_ch.valid <= 1'b0;
			@(posedge clk);
		end
		number_ch.valid <= 1'b1;
		number_ch.payload <= '{number_value: NUM_W'(value)};
		@(posedge clk);
		while (!number_ch.ready) begin
			@(posedge clk);
		end
	endtask

	// stop offering and wait for every outstanding result word
	task automatic drain();
		number_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		int unsigned boundary_sums [8] = '{99, 100, 101, 102, 201, 302, 403, 405};
		body_digits_t dig;
		arst_n = 1'b0;
		steady = 1'b0;
		hold_off_req = 1'b0;
		number_ch.valid <= 1'b0;
		number_ch.payload <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, known good and bad numbers, fold points
		send_number(0);
		send_number(TOP_NUMBER);
		send_number(NUM_MAX);
		send_number(TOP_NUMBER + 1);
		send_number(64'd11223344595);
		send_number(64'd11223344594);
		send_number(64'd11122233344);
		send_number(64'd77712345600);
		send_number(64'd12345677700);
		foreach (boundary_sums[i]) begin
			dig = body_for_sum(boundary_sums[i]);
			send_number(compose(dig, check_of(dig)));
		end
		dig = body_for_sum(100);
		send_number(compose(dig, 99));
		dig = body_for_sum(201);
		send_number(compose(dig, 1));
		send_number(64'd98765432100);
		drain();

		// back to back with no idling on either side
		steady = 1'b1;
		repeat (STEADY_ITEMS) send_number(random_number());
		steady = 1'b0;

		// long result stall while numbers keep coming
		hold_off_req = 1'b1;
		repeat (HOLD_OFF_ITEMS) send_number(random_number());
		drain();

		repeat (TAIL_ITEMS) send_number(random_number());
		drain();
		repeat (2 * LATENCY) @(posedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/snils_pkg.sv
hdl/snils_stream_if.sv
hdl/snils_bcd_split.sv
hdl/snils_check_calc.sv
hdl/snils_number_validator.sv
dv/snils_tb_pkg.sv
dv/snils_checker.sv
dv/tb.sv
